/* rtl/u4dq_pkg.sv */
package u4dq_pkg;

  // Field and accumulator widths.
  localparam int ACT_W = 16;
  localparam int PROD_W = 21;
  localparam int WS_W = 40;
  localparam int AS_W = 32;
  localparam int Q_W = 32;
  localparam int WIDE_W = 63;
  localparam int MAG_W = 62;

  // Saturation limits of the two running sums.
  localparam logic signed [WS_W-1:0] WS_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [WS_W-1:0] WS_MIN = 40'sh80_0000_0000;
  localparam logic signed [AS_W-1:0] AS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [AS_W-1:0] AS_MIN = 32'sh8000_0000;

  // Intermediates are held within plus or minus 2^61.
  localparam logic signed [WIDE_W-1:0] WIDE_MAX = 63'sh2000_0000_0000_0000;
  localparam logic signed [WIDE_W-1:0] WIDE_MIN = 63'sh6000_0000_0000_0000;
  localparam logic [MAG_W-1:0] WIDE_MAG = 62'h2000_0000_0000_0000;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_ALPHA = 2'd0;
  localparam logic [1:0] REG_BETA = 2'd1;
  localparam logic [1:0] REG_GAMMA = 2'd2;
  localparam logic [1:0] REG_MODE = 2'd3;

  // Reset values of the configuration registers.
  localparam logic signed [Q_W-1:0] ALPHA_RESET = 32'sh0001_0000;
  localparam logic signed [Q_W-1:0] BETA_RESET = 32'sh0000_0000;
  localparam logic signed [Q_W-1:0] GAMMA_RESET = 32'sh0001_0000;

  // Epilogue modes; codes 6 and 7 behave as plain.
  localparam logic [2:0] MODE_PLAIN = 3'd0;
  localparam logic [2:0] MODE_BIAS = 3'd1;
  localparam logic [2:0] MODE_BIAS_RELU = 3'd2;
  localparam logic [2:0] MODE_BIAS_GAIN_RES = 3'd3;
  localparam logic [2:0] MODE_TIMES_RES = 3'd4;
  localparam logic [2:0] MODE_BIAS_RES = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_SW,
    ST_MUL_ZA,
    ST_MUL_AD,
    ST_MUL_BP,
    ST_BIAS,
    ST_MUL_RES,
    ST_ADD_RES,
    ST_FIN
  } epi_state_t;

  typedef struct packed {
    logic start;
    logic sh16;
  } mul_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic clip;
  } mul_stat_t;

  typedef struct packed {
    logic signed [WS_W-1:0] ws;
    logic signed [AS_W-1:0] as_sum;
    logic clip;
  } run_sums_t;

  typedef struct packed {
    logic signed [WIDE_W-1:0] value;
    logic clip;
  } wide_sum_t;

  // Add two intermediates and clamp to plus or minus 2^61.
  function automatic wide_sum_t addw(logic signed [WIDE_W-1:0] a,
                                     logic signed [WIDE_W-1:0] b);
    logic signed [WIDE_W:0] s;
    wide_sum_t r;
    s = (WIDE_W+1)'(a) + (WIDE_W+1)'(b);
    r.value = s[WIDE_W-1:0];
    r.clip = 1'b0;
    if (s > (WIDE_W+1)'(WIDE_MAX)) begin
      r.value = WIDE_MAX;
      r.clip = 1'b1;
    end else if (s < (WIDE_W+1)'(WIDE_MIN)) begin
      r.value = WIDE_MIN;
      r.clip = 1'b1;
    end
    return r;
  endfunction

endpackage

/* rtl/u4dq_lane.sv */
module u4dq_lane (
  input  logic signed [u4dq_pkg::ACT_W-1:0]  act,
  input  logic [3:0]                          weight,
  input  logic                                en,
  output logic signed [u4dq_pkg::PROD_W-1:0] prod,
  output logic signed [u4dq_pkg::ACT_W-1:0]  act_used
);

  logic signed [u4dq_pkg::PROD_W-1:0] prod_full;

  // Signed activation times unsigned 4-bit weight.
  assign prod_full = act * $signed({1'b0, weight});

  // A disabled lane contributes nothing to either sum.
  assign prod = en ? prod_full : '0;
  assign act_used = en ? act : '0;

endmodule

/* rtl/u4dq_accum.sv */
module u4dq_accum (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic                                last,
  input  logic signed [u4dq_pkg::PROD_W-1:0] prod0,
  input  logic signed [u4dq_pkg::PROD_W-1:0] prod1,
  input  logic signed [u4dq_pkg::ACT_W-1:0]  act0,
  input  logic signed [u4dq_pkg::ACT_W-1:0]  act1,
  output u4dq_pkg::run_sums_t                 fin
);

  logic signed [u4dq_pkg::WS_W-1:0] ws;
  logic signed [u4dq_pkg::AS_W-1:0] as_sum;
  logic                              clip;
  logic signed [u4dq_pkg::WS_W+1:0] ws_wide;
  logic signed [u4dq_pkg::AS_W+1:0] as_wide;
  logic signed [u4dq_pkg::WS_W-1:0] ws_next;
  logic signed [u4dq_pkg::AS_W-1:0] as_next;
  logic                              clip_next;

  // Merge both lanes into the running sums, saturating at their widths.
  always_comb begin
    ws_wide = (u4dq_pkg::WS_W+2)'(ws) + (u4dq_pkg::WS_W+2)'(prod0)
            + (u4dq_pkg::WS_W+2)'(prod1);
    as_wide = (u4dq_pkg::AS_W+2)'(as_sum) + (u4dq_pkg::AS_W+2)'(act0)
            + (u4dq_pkg::AS_W+2)'(act1);
    clip_next = clip;
    ws_next = ws_wide[u4dq_pkg::WS_W-1:0];
    as_next = as_wide[u4dq_pkg::AS_W-1:0];
    if (ws_wide > (u4dq_pkg::WS_W+2)'(u4dq_pkg::WS_MAX)) begin
      ws_next = u4dq_pkg::WS_MAX;
      clip_next = 1'b1;
    end else if (ws_wide < (u4dq_pkg::WS_W+2)'(u4dq_pkg::WS_MIN)) begin
      ws_next = u4dq_pkg::WS_MIN;
      clip_next = 1'b1;
    end
    if (as_wide > (u4dq_pkg::AS_W+2)'(u4dq_pkg::AS_MAX)) begin
      as_next = u4dq_pkg::AS_MAX;
      clip_next = 1'b1;
    end else if (as_wide < (u4dq_pkg::AS_W+2)'(u4dq_pkg::AS_MIN)) begin
      as_next = u4dq_pkg::AS_MIN;
      clip_next = 1'b1;
    end
  end

  // Running sums; the last request of a run clears them.
  always_ff @(posedge clk) begin
    if (rst) begin
      ws <= '0;
      as_sum <= '0;
      clip <= 1'b0;
    end else if (accept) begin
      if (last) begin
        ws <= '0;
        as_sum <= '0;
        clip <= 1'b0;
      end else begin
        ws <= ws_next;
        as_sum <= as_next;
        clip <= clip_next;
      end
    end
  end

  // Finished sums of a run, held for the epilogue.
  always_ff @(posedge clk) begin
    if (accept && last) begin
      fin.ws <= ws_next;
      fin.as_sum <= as_next;
      fin.clip <= clip_next;
    end
  end

endmodule

/* rtl/u4dq_mul.sv */
module u4dq_mul (
  input  logic                                clk,
  input  logic                                rst,
  input  u4dq_pkg::mul_ctl_t                  ctl,
  input  logic signed [u4dq_pkg::Q_W-1:0]    op_a,
  input  logic signed [u4dq_pkg::WIDE_W-1:0] op_b,
  output u4dq_pkg::mul_stat_t                 stat,
  output logic signed [u4dq_pkg::WIDE_W-1:0] product
);

  localparam int SUM_W = u4dq_pkg::MAG_W + u4dq_pkg::Q_W + 1;
  localparam int HI_W = u4dq_pkg::MAG_W - 32;

  logic                            busy;
  logic                            done;
  logic [1:0]                      phase;
  logic                            neg;
  logic                            sh16;
  logic [u4dq_pkg::Q_W-1:0]        amag;
  logic [u4dq_pkg::MAG_W-1:0]      bmag;
  logic [63:0]                     pp0;
  logic [u4dq_pkg::MAG_W-1:0]      pp1;
  logic [SUM_W-1:0]                psum;
  logic                            clip;
  logic [u4dq_pkg::Q_W-1:0]        a_abs;
  logic [u4dq_pkg::WIDE_W-1:0]     b_abs;
  logic [SUM_W-1:0]                rnd;
  logic [SUM_W-1:0]                shifted;
  logic                            clip_c;
  logic [u4dq_pkg::MAG_W-1:0]      mag;
  logic [u4dq_pkg::WIDE_W-1:0]     mag_ext;

  // Magnitudes of the operands.
  assign a_abs = op_a[u4dq_pkg::Q_W-1] ? (~op_a + 32'd1) : op_a;
  assign b_abs = op_b[u4dq_pkg::WIDE_W-1] ? (~op_b + 63'd1) : op_b;

  // Rounding half away from zero on the magnitude, then the clamp to 2^61.
  assign rnd = sh16 ? SUM_W'(32768) : SUM_W'(2048);
  assign shifted = sh16 ? (psum >> 16) : (psum >> 12);
  assign clip_c = shifted > SUM_W'(u4dq_pkg::WIDE_MAG);
  assign mag = clip_c ? u4dq_pkg::WIDE_MAG : shifted[u4dq_pkg::MAG_W-1:0];
  assign mag_ext = {1'b0, mag};

  // Phase counter: two partial products, a sum, a final shift.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      phase <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        phase <= '0;
      end else if (busy) begin
        phase <= phase + 2'd1;
        if (phase == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath, at most one 32-bit wide multiply per cycle.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      neg <= op_a[u4dq_pkg::Q_W-1] ^ op_b[u4dq_pkg::WIDE_W-1];
      sh16 <= ctl.sh16;
      amag <= a_abs;
      bmag <= b_abs[u4dq_pkg::MAG_W-1:0];
    end else if (busy) begin
      case (phase)
        2'd0: pp0 <= amag * bmag[31:0];
        2'd1: pp1 <= amag * bmag[u4dq_pkg::MAG_W-1:32];
        2'd2: psum <= SUM_W'(pp0) + {1'b0, pp1[HI_W+u4dq_pkg::Q_W-1:0], 32'd0} + rnd;
        default: begin
          clip <= clip_c;
          product <= neg ? (~mag_ext + 63'd1) : mag_ext;
        end
      endcase
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign stat.clip = clip;

endmodule

/* rtl/u4dq_epi.sv */
module u4dq_epi (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [u4dq_pkg::Q_W-1:0]    column_scale,
  input  logic signed [u4dq_pkg::Q_W-1:0]    column_zero,
  input  logic signed [u4dq_pkg::Q_W-1:0]    prior_output,
  input  logic signed [u4dq_pkg::Q_W-1:0]    bias_value,
  input  logic signed [u4dq_pkg::Q_W-1:0]    residual_value,
  input  u4dq_pkg::run_sums_t                 sums,
  input  logic signed [u4dq_pkg::Q_W-1:0]    alpha_gain,
  input  logic signed [u4dq_pkg::Q_W-1:0]    beta_gain,
  input  logic signed [u4dq_pkg::Q_W-1:0]    residual_gain,
  input  logic [2:0]                          epilogue_mode,
  output u4dq_pkg::mul_ctl_t                  mul_ctl,
  output logic signed [u4dq_pkg::Q_W-1:0]    mul_a,
  output logic signed [u4dq_pkg::WIDE_W-1:0] mul_b,
  input  u4dq_pkg::mul_stat_t                 mul_stat,
  input  logic signed [u4dq_pkg::WIDE_W-1:0] mul_product,
  output logic                                idle,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [u4dq_pkg::Q_W-1:0]    result_value,
  output logic                                saturated
);

  u4dq_pkg::epi_state_t state, state_next;

  logic signed [u4dq_pkg::Q_W-1:0]    scale;
  logic signed [u4dq_pkg::Q_W-1:0]    zero;
  logic signed [u4dq_pkg::Q_W-1:0]    prior;
  logic signed [u4dq_pkg::Q_W-1:0]    bias;
  logic signed [u4dq_pkg::Q_W-1:0]    res;
  logic signed [u4dq_pkg::WIDE_W-1:0] x;
  logic signed [u4dq_pkg::WIDE_W-1:0] tmp;
  logic                                sat_flag;
  logic signed [u4dq_pkg::WIDE_W-1:0] add_a;
  logic signed [u4dq_pkg::WIDE_W-1:0] add_b;
  u4dq_pkg::wide_sum_t                 add_out;
  logic                                in_mul;
  logic                                has_bias;
  logic                                times_res;
  logic                                load_out;
  logic signed [u4dq_pkg::Q_W-1:0]    fin_value;
  logic                                fin_clip;

  assign has_bias = epilogue_mode inside {u4dq_pkg::MODE_BIAS, u4dq_pkg::MODE_BIAS_RELU,
                                          u4dq_pkg::MODE_BIAS_GAIN_RES,
                                          u4dq_pkg::MODE_BIAS_RES};
  assign times_res = epilogue_mode == u4dq_pkg::MODE_TIMES_RES;
  assign load_out = (state == u4dq_pkg::ST_FIN) && (!out_valid || out_ready);
  assign idle = state == u4dq_pkg::ST_IDLE;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      u4dq_pkg::ST_IDLE:    if (start) state_next = u4dq_pkg::ST_MUL_SW;
      u4dq_pkg::ST_MUL_SW:  if (mul_stat.done) state_next = u4dq_pkg::ST_MUL_ZA;
      u4dq_pkg::ST_MUL_ZA:  if (mul_stat.done) state_next = u4dq_pkg::ST_MUL_AD;
      u4dq_pkg::ST_MUL_AD:  if (mul_stat.done) state_next = u4dq_pkg::ST_MUL_BP;
      u4dq_pkg::ST_MUL_BP:  if (mul_stat.done) state_next = u4dq_pkg::ST_BIAS;
      u4dq_pkg::ST_BIAS: begin
        if (epilogue_mode == u4dq_pkg::MODE_BIAS_GAIN_RES || times_res) begin
          state_next = u4dq_pkg::ST_MUL_RES;
        end else if (epilogue_mode == u4dq_pkg::MODE_BIAS_RES) begin
          state_next = u4dq_pkg::ST_ADD_RES;
        end else begin
          state_next = u4dq_pkg::ST_FIN;
        end
      end
      u4dq_pkg::ST_MUL_RES: if (mul_stat.done) state_next = u4dq_pkg::ST_FIN;
      u4dq_pkg::ST_ADD_RES: state_next = u4dq_pkg::ST_FIN;
      u4dq_pkg::ST_FIN:     if (load_out) state_next = u4dq_pkg::ST_IDLE;
      default:              state_next = u4dq_pkg::ST_IDLE;
    endcase
  end

  // Multiplier requests and adder operands for each state.
  always_comb begin
    in_mul = 1'b0;
    mul_ctl.sh16 = 1'b1;
    mul_a = scale;
    mul_b = (u4dq_pkg::WIDE_W)'(sums.ws);
    add_a = x;
    add_b = mul_product;
    case (state)
      u4dq_pkg::ST_MUL_SW: begin
        in_mul = 1'b1;
        mul_ctl.sh16 = 1'b0;
      end
      u4dq_pkg::ST_MUL_ZA: begin
        in_mul = 1'b1;
        mul_ctl.sh16 = 1'b0;
        mul_a = zero;
        mul_b = (u4dq_pkg::WIDE_W)'(sums.as_sum);
      end
      u4dq_pkg::ST_MUL_AD: begin
        in_mul = 1'b1;
        mul_a = alpha_gain;
        mul_b = x;
      end
      u4dq_pkg::ST_MUL_BP: begin
        in_mul = 1'b1;
        mul_a = beta_gain;
        mul_b = (u4dq_pkg::WIDE_W)'(prior);
        add_a = tmp;
      end
      u4dq_pkg::ST_BIAS: begin
        add_b = (u4dq_pkg::WIDE_W)'(bias);
      end
      u4dq_pkg::ST_MUL_RES: begin
        in_mul = 1'b1;
        mul_a = times_res ? res : residual_gain;
        mul_b = times_res ? x : (u4dq_pkg::WIDE_W)'(res);
      end
      u4dq_pkg::ST_ADD_RES: begin
        add_b = (u4dq_pkg::WIDE_W)'(res);
      end
      default: begin
        in_mul = 1'b0;
      end
    endcase
    mul_ctl.start = in_mul && !mul_stat.busy && !mul_stat.done;
  end

  // One shared clamping adder.
  assign add_out = u4dq_pkg::addw(add_a, add_b);

  // Final clamp to the Q16.16 range.
  always_comb begin
    fin_value = x[u4dq_pkg::Q_W-1:0];
    fin_clip = 1'b0;
    if (x > (u4dq_pkg::WIDE_W)'(u4dq_pkg::AS_MAX)) begin
      fin_value = u4dq_pkg::AS_MAX;
      fin_clip = 1'b1;
    end else if (x < (u4dq_pkg::WIDE_W)'(u4dq_pkg::AS_MIN)) begin
      fin_value = u4dq_pkg::AS_MIN;
      fin_clip = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= u4dq_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers of the epilogue.
  always_ff @(posedge clk) begin
    if (load_out) begin
      result_value <= fin_value;
      saturated <= sat_flag | fin_clip;
    end
    case (state)
      u4dq_pkg::ST_IDLE: begin
        if (start) begin
          scale <= column_scale;
          zero <= column_zero;
          prior <= prior_output;
          bias <= bias_value;
          res <= residual_value;
        end
      end
      u4dq_pkg::ST_MUL_SW: begin
        if (mul_stat.done) begin
          x <= mul_product;
          sat_flag <= sums.clip | mul_stat.clip;
        end
      end
      u4dq_pkg::ST_MUL_ZA, u4dq_pkg::ST_MUL_BP: begin
        if (mul_stat.done) begin
          x <= add_out.value;
          sat_flag <= sat_flag | mul_stat.clip | add_out.clip;
        end
      end
      u4dq_pkg::ST_MUL_AD: begin
        if (mul_stat.done) begin
          tmp <= mul_product;
          sat_flag <= sat_flag | mul_stat.clip;
        end
      end
      u4dq_pkg::ST_BIAS: begin
        if (has_bias) begin
          sat_flag <= sat_flag | add_out.clip;
          if (epilogue_mode == u4dq_pkg::MODE_BIAS_RELU && add_out.value < 0) begin
            x <= '0;
          end else begin
            x <= add_out.value;
          end
        end
      end
      u4dq_pkg::ST_MUL_RES: begin
        if (mul_stat.done) begin
          if (times_res) begin
            x <= mul_product;
            sat_flag <= sat_flag | mul_stat.clip;
          end else begin
            x <= add_out.value;
            sat_flag <= sat_flag | mul_stat.clip | add_out.clip;
          end
        end
      end
      u4dq_pkg::ST_ADD_RES: begin
        x <= add_out.value;
        sat_flag <= sat_flag | add_out.clip;
      end
      default: begin
        sat_flag <= sat_flag;
      end
    endcase
  end

endmodule

/* rtl/uint4_dequant_dot_with_epilogue_unit.sv */
// Channel   Handshake                    Payload
// in        in_valid / in_ready          act_even .. residual_value
// out       out_valid / out_ready        result_value, saturated
// config    psel, penable, pwrite, pready paddr, pwdata, prdata
//
// While the epilogue is idle, items that are not the last of a run are taken one per
// cycle; two lanes form weighted products that a merge stage adds to saturating sums.
// The last item of a run starts the epilogue, which holds in_ready low until it is
// idle again: a shared multiplier runs four or five products in turn, plus the adds
// and the final clamp.
// Reset (rst, synchronous) clears the running sums, the sequencer and out_valid
// and loads the gain and mode registers with their defaults.
// A result waiting on out_ready does not block accumulation of the next run; only its
// epilogue waits at the final step until the output register is free.
module uint4_dequant_dot_with_epilogue_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [u4dq_pkg::ACT_W-1:0]  act_even,
  input  logic signed [u4dq_pkg::ACT_W-1:0]  act_odd,
  input  logic [7:0]                          weight_pair,
  input  logic                                second_valid,
  input  logic                                last_pair,
  input  logic signed [u4dq_pkg::Q_W-1:0]    column_scale,
  input  logic signed [u4dq_pkg::Q_W-1:0]    column_zero,
  input  logic signed [u4dq_pkg::Q_W-1:0]    prior_output,
  input  logic signed [u4dq_pkg::Q_W-1:0]    bias_value,
  input  logic signed [u4dq_pkg::Q_W-1:0]    residual_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [u4dq_pkg::Q_W-1:0]    result_value,
  output logic                                saturated,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [3:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  logic signed [u4dq_pkg::Q_W-1:0]    alpha_gain;
  logic signed [u4dq_pkg::Q_W-1:0]    beta_gain;
  logic signed [u4dq_pkg::Q_W-1:0]    residual_gain;
  logic [2:0]                          epilogue_mode;
  logic                                cfg_write;
  logic                                accept;
  logic                                epi_idle;
  logic signed [u4dq_pkg::PROD_W-1:0] prod0;
  logic signed [u4dq_pkg::PROD_W-1:0] prod1;
  logic signed [u4dq_pkg::ACT_W-1:0]  act0;
  logic signed [u4dq_pkg::ACT_W-1:0]  act1;
  u4dq_pkg::run_sums_t                 sums;
  u4dq_pkg::mul_ctl_t                  mul_ctl;
  u4dq_pkg::mul_stat_t                 mul_stat;
  logic signed [u4dq_pkg::Q_W-1:0]    mul_a;
  logic signed [u4dq_pkg::WIDE_W-1:0] mul_b;
  logic signed [u4dq_pkg::WIDE_W-1:0] mul_product;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign in_ready = epi_idle;
  assign accept = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_gain <= u4dq_pkg::ALPHA_RESET;
      beta_gain <= u4dq_pkg::BETA_RESET;
      residual_gain <= u4dq_pkg::GAMMA_RESET;
      epilogue_mode <= u4dq_pkg::MODE_PLAIN;
    end else if (cfg_write) begin
      case (paddr[3:2])
        u4dq_pkg::REG_ALPHA: alpha_gain <= pwdata;
        u4dq_pkg::REG_BETA:  beta_gain <= pwdata;
        u4dq_pkg::REG_GAMMA: residual_gain <= pwdata;
        u4dq_pkg::REG_MODE:  epilogue_mode <= pwdata[2:0];
        default:             epilogue_mode <= epilogue_mode;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[3:2])
      u4dq_pkg::REG_ALPHA: prdata = alpha_gain;
      u4dq_pkg::REG_BETA:  prdata = beta_gain;
      u4dq_pkg::REG_GAMMA: prdata = residual_gain;
      u4dq_pkg::REG_MODE:  prdata = {29'd0, epilogue_mode};
      default:             prdata = '0;
    endcase
  end

  // Even lane takes the low nibble, odd lane the high nibble.
  u4dq_lane u_lane_even (
    .act      (act_even),
    .weight   (weight_pair[3:0]),
    .en       (1'b1),
    .prod     (prod0),
    .act_used (act0)
  );

  u4dq_lane u_lane_odd (
    .act      (act_odd),
    .weight   (weight_pair[7:4]),
    .en       (second_valid),
    .prod     (prod1),
    .act_used (act1)
  );

  u4dq_accum u_accum (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .last   (last_pair),
    .prod0  (prod0),
    .prod1  (prod1),
    .act0   (act0),
    .act1   (act1),
    .fin    (sums)
  );

  u4dq_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mul_ctl),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .stat    (mul_stat),
    .product (mul_product)
  );

  u4dq_epi u_epi (
    .clk            (clk),
    .rst            (rst),
    .start          (accept && last_pair),
    .column_scale   (column_scale),
    .column_zero    (column_zero),
    .prior_output   (prior_output),
    .bias_value     (bias_value),
    .residual_value (residual_value),
    .sums           (sums),
    .alpha_gain     (alpha_gain),
    .beta_gain      (beta_gain),
    .residual_gain  (residual_gain),
    .epilogue_mode  (epilogue_mode),
    .mul_ctl        (mul_ctl),
    .mul_a          (mul_a),
    .mul_b          (mul_b),
    .mul_stat       (mul_stat),
    .mul_product    (mul_product),
    .idle           (epi_idle),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_value   (result_value),
    .saturated      (saturated)
  );

endmodule
